// ===== hdl/cswrle_pkg.sv =====
// ----------------------------------------------------------------------------
// cswrle_pkg
// Shared widths, register indexes and status codes of the CSW pulse decoder.
// ----------------------------------------------------------------------------
package cswrle_pkg;

    localparam int unsigned C_SAMPLE_W = 32;   // extended run length
    localparam int unsigned C_DIGIT_W  = 8;    // multiplier digit
    localparam int unsigned C_RATE_W   = 24;   // sample rate register
    localparam int unsigned C_COUNT_W  = 25;   // pulse counters
    localparam int unsigned C_TICK_W   = 54;   // tick count
    localparam int unsigned C_TICK_K_W = 22;   // width of the tick rate

    localparam logic [C_TICK_K_W-1:0] C_TICK_RATE  = 22'd3500000;
    localparam logic [C_COUNT_W-1:0]  C_MAX_PULSES = 25'd16777216;
    localparam logic [C_RATE_W-1:0]   C_RATE_RESET = 24'd44100;

    // configuration register indexes
    localparam logic C_REG_RATE        = 1'b0;
    localparam logic C_REG_PULSE_TOTAL = 1'b1;

    // result status codes
    localparam logic [2:0] C_ST_PULSE     = 3'd0;
    localparam logic [2:0] C_ST_BLOCK_OK  = 3'd1;
    localparam logic [2:0] C_ST_TRUNC     = 3'd2;
    localparam logic [2:0] C_ST_EXT_TRUNC = 3'd3;
    localparam logic [2:0] C_ST_ZERO      = 3'd4;
    localparam logic [2:0] C_ST_TRAILING  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

endpackage

// ===== hdl/cswrle_mul.sv =====
// ----------------------------------------------------------------------------
// cswrle_mul
// Digit-serial multiply of a sample count by the tick rate, plus a rounding
// term; one byte of the sample count per cycle, most significant first.
// ----------------------------------------------------------------------------
module cswrle_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [cswrle_pkg::C_SAMPLE_W-1:0]  i_samples,
    input  logic [cswrle_pkg::C_RATE_W-2:0]    i_half,
    output logic                               o_done,
    output logic [cswrle_pkg::C_TICK_W-1:0]    o_product
);

    localparam int unsigned DIGITS = cswrle_pkg::C_SAMPLE_W / cswrle_pkg::C_DIGIT_W;
    localparam int unsigned CNT_W  = $clog2(DIGITS);
    localparam int unsigned PP_W   = cswrle_pkg::C_DIGIT_W + cswrle_pkg::C_TICK_K_W;
    localparam int unsigned SW     = cswrle_pkg::C_SAMPLE_W;
    localparam int unsigned TW     = cswrle_pkg::C_TICK_W;
    localparam int unsigned DW     = cswrle_pkg::C_DIGIT_W;

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [SW-1:0]                 r_smp;
    logic [cswrle_pkg::C_RATE_W-2:0] r_half;
    logic [TW-1:0]                 r_acc;

    logic [DW-1:0]                 w_digit;
    logic [PP_W-1:0]               w_pp;
    logic                          w_last;
    logic [TW-1:0]                 n_acc;

    always_comb begin
        w_digit = r_smp[SW-1 -: DW];
        w_pp    = PP_W'(w_digit) * PP_W'(cswrle_pkg::C_TICK_RATE);
        w_last  = (r_cnt == CNT_W'(DIGITS - 1));
        // Horner step; the rounding term joins on the final digit
        n_acc   = {r_acc[TW-DW-1:0], {DW{1'b0}}} + TW'(w_pp)
                + (w_last ? TW'(r_half) : {TW{1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last)
                    r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_smp  <= i_samples;
            r_half <= i_half;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_smp <= {r_smp[SW-DW-1:0], {DW{1'b0}}};
            r_acc <= n_acc;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== hdl/cswrle_div.sv =====
// ----------------------------------------------------------------------------
// cswrle_div
// Bit-serial restoring divider: one quotient bit per cycle, the quotient
// shifting in behind the dividend in the same register.
// ----------------------------------------------------------------------------
module cswrle_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cswrle_pkg::C_TICK_W-1:0]   i_num,
    input  logic [cswrle_pkg::C_RATE_W-1:0]   i_den,
    output logic                              o_done,
    output logic [cswrle_pkg::C_TICK_W-1:0]   o_quot
);

    localparam int unsigned TW    = cswrle_pkg::C_TICK_W;
    localparam int unsigned RW    = cswrle_pkg::C_RATE_W;
    localparam int unsigned CNT_W = $clog2(TW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TW-1:0]     r_num;
    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_den;

    logic [RW:0]       w_trial;
    logic [RW:0]       w_diff;
    logic              w_ge;
    logic              w_last;

    always_comb begin
        w_trial = {r_rem, r_num[TW-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        w_last  = (r_cnt == CNT_W'(TW - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last)
                    r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            // partial remainder stays below the divisor, so RW bits hold it
            r_rem <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_num <= {r_num[TW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== hdl/csw_rle_pulse_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// csw_rle_pulse_decoder_unit
// Turns CSW run-length bytes into pulse lengths in 3.5 MHz ticks.
// ----------------------------------------------------------------------------
// Input stream: one word per byte of the pulse block. tdata carries the byte,
// tuser is 1 when the byte is present (0 for an empty end marker), tlast
// closes the block. Output stream: one word per pulse or error, and for the
// last input word one word with any pulse or error and the end (none if the
// block already failed); tuser holds pulse_valid and status, tlast marks it.
// Configuration: write the sample rate (index 0) and the pulse total (index 1)
// while the unit is idle; a zero rate counts as 1.
// Sequence: a byte that yields a pulse is multiplied byte-wide by the tick
// rate, then divided by the sample rate in the one-bit-per-cycle divider, and
// its result waits in the pending register until the output register is free;
// words with no pulse go straight to that handoff. Escape and length bytes
// that complete nothing leave the unit idle and ready for the next byte.
// The input is held off while a word is in conversion or in handoff.
// Reset: registers return to 44100 Hz and a pulse total of zero, the block
// state clears and the output is empty.
// Stall: a finished word waits in the output register; the next input word is
// accepted meanwhile, and the result after it waits until that one is taken.
// ----------------------------------------------------------------------------
module csw_rle_pulse_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [24:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [53:0] pulse_ticks, [55:54] zero
    output logic [3:0]  m_axis_tuser,   // [0] pulse_valid, [3:1] status
    output logic        m_axis_tlast    // block_end
);

    localparam int unsigned SW = cswrle_pkg::C_SAMPLE_W;
    localparam int unsigned TW = cswrle_pkg::C_TICK_W;
    localparam int unsigned CW = cswrle_pkg::C_COUNT_W;
    localparam int unsigned RW = cswrle_pkg::C_RATE_W;

    // configuration
    logic [RW-1:0]        r_rate_hz;
    logic [CW-1:0]        r_pulse_total;

    // block state
    logic [2:0]           r_esc;
    logic [SW-1:0]        r_acc;
    logic [CW-1:0]        r_done;
    logic                 r_failed;
    logic [2:0]           n_esc;
    logic [SW-1:0]        n_acc;
    logic [CW-1:0]        n_done;
    logic                 n_failed;

    cswrle_pkg::t_state   r_state;

    // pending result
    logic                 r_pend_valid;
    logic [2:0]           r_pend_status;
    logic                 r_pend_end;
    logic [TW-1:0]        r_pend_ticks;

    // output register
    logic                 r_m_valid;
    logic [TW-1:0]        r_m_ticks;
    logic                 r_m_pulse;
    logic [2:0]           r_m_status;
    logic                 r_m_end;

    logic                 w_in_acc;
    logic [RW-1:0]        w_rate;
    logic [CW-1:0]        w_lim;
    logic [SW-1:0]        w_acc_full;
    logic                 w_have_pulse;
    logic                 w_errored;
    logic [2:0]           w_err;
    logic                 w_result;
    logic [2:0]           w_status;
    logic                 w_end;
    logic [SW-1:0]        w_samples;
    logic                 w_out_free;

    logic                 w_mul_done;
    logic [TW-1:0]        w_product;
    logic                 w_div_done;
    logic [TW-1:0]        w_quot;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == cswrle_pkg::ST_IDLE);
    assign w_rate        = (r_rate_hz == '0) ? RW'(1) : r_rate_hz;
    assign w_lim         = (r_pulse_total > cswrle_pkg::C_MAX_PULSES)
                         ? cswrle_pkg::C_MAX_PULSES : r_pulse_total;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // extended length byte placed little-endian by escape phase
    always_comb begin
        case (r_esc)
            3'd1:    w_acc_full = r_acc | {24'b0, s_axis_tdata};
            3'd2:    w_acc_full = r_acc | {16'b0, s_axis_tdata, 8'b0};
            3'd3:    w_acc_full = r_acc | {8'b0, s_axis_tdata, 16'b0};
            3'd4:    w_acc_full = r_acc | {s_axis_tdata, 24'b0};
            default: w_acc_full = r_acc;
        endcase
    end

    always_comb begin
        n_esc        = r_esc;
        n_acc        = r_acc;
        n_done       = r_done;
        n_failed     = r_failed;
        w_have_pulse = 1'b0;
        w_errored    = 1'b0;
        w_err        = cswrle_pkg::C_ST_PULSE;
        w_result     = 1'b0;
        w_status     = cswrle_pkg::C_ST_PULSE;
        w_end        = 1'b0;
        w_samples    = '0;
        if (w_in_acc) begin
            if (r_failed) begin
                if (s_axis_tlast) begin
                    n_esc    = '0;
                    n_acc    = '0;
                    n_done   = '0;
                    n_failed = 1'b0;
                end
            end else begin
                if (s_axis_tuser) begin
                    if (r_esc == 3'd0) begin
                        if (r_done >= w_lim) begin
                            w_errored = 1'b1;
                            w_err     = cswrle_pkg::C_ST_TRAILING;
                        end else if (s_axis_tdata != 8'd0) begin
                            w_have_pulse = 1'b1;
                            w_samples    = SW'(s_axis_tdata);
                            n_done       = r_done + 1'b1;
                        end else begin
                            n_esc = 3'd1;
                            n_acc = '0;
                        end
                    end else if (r_esc == 3'd4) begin
                        n_esc = '0;
                        n_acc = '0;
                        if (w_acc_full == '0) begin
                            w_errored = 1'b1;
                            w_err     = cswrle_pkg::C_ST_ZERO;
                        end else begin
                            w_have_pulse = 1'b1;
                            w_samples    = w_acc_full;
                            n_done       = r_done + 1'b1;
                        end
                    end else begin
                        n_esc = r_esc + 3'd1;
                        n_acc = w_acc_full;
                    end
                end
                if (!s_axis_tlast) begin
                    if (w_errored) begin
                        w_result = 1'b1;
                        w_status = w_err;
                        n_failed = 1'b1;
                    end else if (w_have_pulse) begin
                        w_result = 1'b1;
                    end
                end else begin
                    w_result = 1'b1;
                    w_end    = 1'b1;
                    if (w_errored)
                        w_status = w_err;
                    else if (n_esc != 3'd0)
                        w_status = cswrle_pkg::C_ST_EXT_TRUNC;
                    else if (n_done < w_lim)
                        w_status = cswrle_pkg::C_ST_TRUNC;
                    else
                        w_status = cswrle_pkg::C_ST_BLOCK_OK;
                    n_esc    = '0;
                    n_acc    = '0;
                    n_done   = '0;
                    n_failed = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_hz     <= cswrle_pkg::C_RATE_RESET;
            r_pulse_total <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cswrle_pkg::C_REG_RATE:        r_rate_hz     <= i_cfg_wdata[RW-1:0];
                cswrle_pkg::C_REG_PULSE_TOTAL: r_pulse_total <= i_cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= '0;
            r_acc    <= '0;
            r_done   <= '0;
            r_failed <= 1'b0;
        end else begin
            r_esc    <= n_esc;
            r_acc    <= n_acc;
            r_done   <= n_done;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cswrle_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == cswrle_pkg::ST_EMIT && w_out_free)
                r_m_valid <= 1'b1;
            else if (m_axis_tready)
                r_m_valid <= 1'b0;
            unique case (r_state)
                cswrle_pkg::ST_IDLE: begin
                    if (w_result)
                        r_state <= w_have_pulse ? cswrle_pkg::ST_CONV : cswrle_pkg::ST_EMIT;
                end
                cswrle_pkg::ST_CONV: begin
                    if (w_div_done)
                        r_state <= cswrle_pkg::ST_EMIT;
                end
                cswrle_pkg::ST_EMIT: begin
                    if (w_out_free)
                        r_state <= cswrle_pkg::ST_IDLE;
                end
                default: r_state <= cswrle_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_pend_valid  <= w_have_pulse;
            r_pend_status <= w_status;
            r_pend_end    <= w_end;
            r_pend_ticks  <= '0;
        end else if (w_div_done) begin
            // round-to-nearest can give zero for very high rates
            r_pend_ticks <= (w_quot == '0) ? TW'(1) : w_quot;
        end
        if (r_state == cswrle_pkg::ST_EMIT && w_out_free) begin
            r_m_ticks  <= r_pend_ticks;
            r_m_pulse  <= r_pend_valid;
            r_m_status <= r_pend_status;
            r_m_end    <= r_pend_end;
        end
    end

    cswrle_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_in_acc && w_have_pulse),
        .i_samples (w_samples),
        .i_half    (w_rate[RW-1:1]),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    cswrle_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_done),
        .i_num   (w_product),
        .i_den   (w_rate),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_ticks};
    assign m_axis_tuser  = {r_m_status, r_m_pulse};
    assign m_axis_tlast  = r_m_end;

    a_esc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc <= 3'd4)
        else $error("escape phase out of range");

    a_pulse_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_pulse |-> r_m_ticks != '0)
        else $error("pulse word with zero ticks");

    a_nopulse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !r_m_pulse |-> r_m_ticks == '0 && r_m_status != cswrle_pkg::C_ST_PULSE)
        else $error("non-pulse word carries ticks or pulse status");

    a_div_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == cswrle_pkg::ST_CONV)
        else $error("divider finished outside conversion");

    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && s_axis_tlast |=> r_esc == 3'd0 && r_done == '0 && !r_failed)
        else $error("block state not cleared after last word");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CSW run-length pulse decoder.
// A directed table walks the status codes and the field extremes, then
// random blocks of pulse bytes run under several register settings and traffic
// patterns. Output words are checked against the table row's word if any,
// else an in-bench decoder tracking escape phase, pulse count and error latch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 150;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic                            valid;
        logic [cswrle_pkg::C_TICK_W-1:0] ticks;
        logic [2:0]                      status;
        logic                            blk_end;
    } t_pulse_res;

    typedef struct packed {
        logic [7:0] b;
        logic       has;
        logic       last;
    } t_word;

    typedef enum logic [1:0] {ROW_WORD, ROW_RATE, ROW_TOTAL} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [24:0] value;     // data byte or register value
        logic        has;
        logic        last;
        logic        typed;     // res is the expected word
        t_pulse_res  res;
    } t_stim_row;

    localparam t_pulse_res NO_RES = '0;
    localparam int N_ROWS = 27;

    // Directed table: reset defaults are 44100 Hz and a pulse total of zero.
    localparam t_stim_row PLAN [N_ROWS] = '{
        '{ROW_WORD,  25'h01, 1'b1, 1'b0, 1'b1, '{1'b0, 54'd0, cswrle_pkg::C_ST_TRAILING, 1'b0}},
        '{ROW_WORD,  25'h00, 1'b0, 1'b1, 1'b0, NO_RES},   // silent close
        '{ROW_WORD,  25'h00, 1'b0, 1'b1, 1'b1, '{1'b0, 54'd0, cswrle_pkg::C_ST_BLOCK_OK, 1'b1}},
        '{ROW_TOTAL, 25'd3,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h01, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h00, 1'b0, 1'b0, 1'b0, NO_RES},   // empty, ignored
        '{ROW_WORD,  25'h00, 1'b1, 1'b0, 1'b0, NO_RES},   // escape
        '{ROW_WORD,  25'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h00, 1'b1, 1'b0, 1'b1, '{1'b0, 54'd0, cswrle_pkg::C_ST_ZERO, 1'b0}},
        '{ROW_WORD,  25'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD,  25'h05, 1'b1, 1'b1, 1'b0, NO_RES},   // pulse + truncated
        '{ROW_WORD,  25'h00, 1'b1, 1'b1, 1'b1, '{1'b0, 54'd0, cswrle_pkg::C_ST_EXT_TRUNC, 1'b1}},
        '{ROW_RATE,  25'd1,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_TOTAL, 25'h1FFFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'hFF, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'hFF, 1'b1, 1'b0, 1'b1,
          '{1'b1, 54'd15032385532500000, cswrle_pkg::C_ST_PULSE, 1'b0}},
        '{ROW_WORD,  25'h00, 1'b0, 1'b1, 1'b1, '{1'b0, 54'd0, cswrle_pkg::C_ST_TRUNC, 1'b1}},
        '{ROW_TOTAL, 25'd1,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h02, 1'b1, 1'b1, 1'b0, NO_RES},   // pulse + block ok
        '{ROW_WORD,  25'h03, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD,  25'h04, 1'b1, 1'b1, 1'b1, '{1'b0, 54'd0, cswrle_pkg::C_ST_TRAILING, 1'b1}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [24:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    csw_rle_pulse_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // decoder copy: registers and block state
    logic [cswrle_pkg::C_RATE_W-1:0]  rate_reg;
    logic [cswrle_pkg::C_COUNT_W-1:0] total_reg;
    logic [2:0]                       esc_phase;
    logic [31:0]                      ext_len;
    logic [cswrle_pkg::C_COUNT_W-1:0] pulse_tally;
    logic                             blk_failed;

    t_pulse_res pending_pulses[$];
    int         bad_count;
    int         stuck_cycles;
    int         words_sent;
    int         traffic_mode;   // 0 none, 1 sender gaps, 2 receiver stalls, 3 both

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void restart_block();
        esc_phase   = '0;
        ext_len     = '0;
        pulse_tally = '0;
        blk_failed  = 1'b0;
    endfunction

    function automatic logic [cswrle_pkg::C_COUNT_W-1:0] pulse_cap();
        return (total_reg > cswrle_pkg::C_MAX_PULSES) ? cswrle_pkg::C_MAX_PULSES : total_reg;
    endfunction

    // samples -> 3.5 MHz ticks, rounded to nearest, never below one
    function automatic logic [cswrle_pkg::C_TICK_W-1:0] ticks_for(input logic [31:0] samples);
        longint unsigned rate;
        longint unsigned t;
        rate = (rate_reg == '0) ? 64'd1 : {40'd0, rate_reg};
        t = ({32'd0, samples} * {42'd0, cswrle_pkg::C_TICK_RATE} + rate / 2) / rate;
        if (t == 0)
            t = 1;
        return t[cswrle_pkg::C_TICK_W-1:0];
    endfunction

    function automatic bit decode_word(input t_word w, output t_pulse_res r);
        bit                              got;
        bit                              errored;
        logic [cswrle_pkg::C_TICK_W-1:0] ticks;
        logic [2:0]                      code;
        got     = 1'b0;
        errored = 1'b0;
        ticks   = '0;
        code    = cswrle_pkg::C_ST_PULSE;
        r       = '0;
        if (blk_failed) begin
            if (w.last)
                restart_block();
            return 1'b0;
        end
        if (w.has) begin
            if (esc_phase == 3'd0) begin
                if (pulse_tally >= pulse_cap()) begin
                    code    = cswrle_pkg::C_ST_TRAILING;
                    errored = 1'b1;
                end else if (w.b != 8'd0) begin
                    ticks       = ticks_for({24'd0, w.b});
                    got         = 1'b1;
                    pulse_tally = pulse_tally + 1'b1;
                end else begin
                    esc_phase = 3'd1;
                    ext_len   = '0;
                end
            end else begin
                // little-endian length bytes
                ext_len = ext_len | ({24'd0, w.b} << (8 * (esc_phase - 3'd1)));
                if (esc_phase == 3'd4) begin
                    esc_phase = 3'd0;
                    if (ext_len == '0) begin
                        code    = cswrle_pkg::C_ST_ZERO;
                        errored = 1'b1;
                    end else begin
                        ticks       = ticks_for(ext_len);
                        got         = 1'b1;
                        pulse_tally = pulse_tally + 1'b1;
                    end
                    ext_len = '0;
                end else begin
                    esc_phase = esc_phase + 3'd1;
                end
            end
        end
        if (!w.last) begin
            if (errored) begin
                blk_failed = 1'b1;
                r.status   = code;
                return 1'b1;
            end
            if (got) begin
                r.valid  = 1'b1;
                r.ticks  = ticks;
                r.status = cswrle_pkg::C_ST_PULSE;
                return 1'b1;
            end
            return 1'b0;
        end
        if (!errored) begin
            if (esc_phase != 3'd0)
                code = cswrle_pkg::C_ST_EXT_TRUNC;
            else if (pulse_tally < pulse_cap())
                code = cswrle_pkg::C_ST_TRUNC;
            else
                code = cswrle_pkg::C_ST_BLOCK_OK;
        end
        r.valid   = got;
        r.ticks   = got ? ticks : '0;
        r.status  = code;
        r.blk_end = 1'b1;
        restart_block();
        return 1'b1;
    endfunction

    function automatic t_word mk_word(input logic [7:0] b, input logic h, input logic l);
        t_word w;
        w.b    = b;
        w.has  = h;
        w.last = l;
        return w;
    endfunction

    function automatic bit sender_gap();
        int pct;
        pct = (traffic_mode == 1) ? 57 : (traffic_mode == 3) ? 33 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit rx_stall();
        int pct;
        pct = (traffic_mode == 2) ? 57 : (traffic_mode == 3) ? 33 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void log_bad(input string what, input t_pulse_res want,
                                    input t_pulse_res got);
        bad_count++;
        if (bad_count <= REPORT_MAX) begin
            $display("tb: %s exp valid=%0b ticks=%0d status=%0d end=%0b",
                     what, want.valid, want.ticks, want.status, want.blk_end);
            $display("tb:   got valid=%0b ticks=%0d status=%0d end=%0b",
                     got.valid, got.ticks, got.status, got.blk_end);
        end
    endfunction

    task automatic send_word(input t_word w, input bit typed, input t_pulse_res typed_res);
        t_pulse_res r;
        bit         hit;
        while (sender_gap()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.b;
        s_axis_tuser  <= w.has;
        s_axis_tlast  <= w.last;
        hit = decode_word(w, r);
        if (hit || typed)
            pending_pulses.insert(pending_pulses.size(), typed ? typed_res : r);
        if (w.has || w.last)
            words_sent++;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // drain results, then give no-result words time to clear the pipeline
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [24:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == cswrle_pkg::C_REG_RATE)
            rate_reg = val[cswrle_pkg::C_RATE_W-1:0];
        else
            total_reg = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One block: mostly well-formed pulses, sometimes noise or a cut-off end.
    task automatic random_block();
        t_word        seq[$];
        t_word        w;
        int           cap;
        int           n;
        int           k;
        logic [31:0]  len;
        cap = int'(pulse_cap());
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(1, 8);
            for (int i = 0; i < k; i++)
                seq.insert(seq.size(), mk_word(8'($urandom_range(0, 255)),
                                               1'($urandom_range(0, 1)), i == k - 1));
        end else begin
            if (cap > 24)
                n = $urandom_range(0, 16);
            else begin
                case ($urandom_range(0, 3))
                    0, 1: n = cap;
                    2: n = $urandom_range(0, cap);
                    default: n = cap + $urandom_range(1, 2);
                endcase
            end
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 7) == 0)
                    seq.insert(seq.size(), mk_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
                if ($urandom_range(0, 3) != 0)
                    seq.insert(seq.size(), mk_word(8'($urandom_range(1, 255)), 1'b1, 1'b0));
                else begin
                    case ($urandom_range(0, 9))
                        0: len = '0;
                        1, 2, 3: len = $urandom_range(1, 4095);
                        default: len = $urandom;
                    endcase
                    seq.insert(seq.size(), mk_word(8'h00, 1'b1, 1'b0));
                    for (int j = 0; j < 4; j++)
                        seq.insert(seq.size(), mk_word(len[8*j +: 8], 1'b1, 1'b0));
                end
            end
            case ($urandom_range(0, 7))
                0, 1, 2, 3:
                    seq.insert(seq.size(), mk_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
                4, 5: begin
                    if (seq.size() == 0)
                        seq.insert(seq.size(), mk_word(8'h00, 1'b0, 1'b1));
                    else begin
                        w = seq.pop_back();
                        w.last = 1'b1;
                        seq.insert(seq.size(), w);
                    end
                end
                default: begin
                    // end inside an extended length
                    k = $urandom_range(0, 3);
                    seq.insert(seq.size(), mk_word(8'h00, 1'b1, k == 0));
                    for (int j = 0; j < k; j++)
                        seq.insert(seq.size(), mk_word(8'($urandom_range(0, 255)), 1'b1,
                                                       j == k - 1));
                end
            endcase
        end
        foreach (seq[i])
            send_word(seq[i], 1'b0, NO_RES);
    endtask

    always @(posedge i_clk) begin : rx_side
        t_pulse_res got;
        t_pulse_res want;
        bit         s_hit;
        bit         m_hit;
        m_axis_tready <= !rx_stall();
        if (i_rst_n) begin
            s_hit = s_axis_tvalid && s_axis_tready;
            m_hit = m_axis_tvalid && m_axis_tready;
            if (m_hit) begin
                got.valid   = m_axis_tuser[0];
                got.ticks   = m_axis_tdata[cswrle_pkg::C_TICK_W-1:0];
                got.status  = m_axis_tuser[3:1];
                got.blk_end = m_axis_tlast;
                if (pending_pulses.size() == 0)
                    log_bad("unexpected word", NO_RES, got);
                else begin
                    want = pending_pulses.pop_front();
                    if (got.valid !== want.valid || got.ticks !== want.ticks ||
                        got.status !== want.status || got.blk_end !== want.blk_end)
                        log_bad("mismatch", want, got);
                end
            end
            stuck_cycles = (s_hit || m_hit) ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stim
        logic [24:0] new_rate;
        logic [24:0] new_total;
        int          phase_start;
        bit          held;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        bad_count     = 0;
        stuck_cycles  = 0;
        words_sent    = 0;
        traffic_mode  = 0;
        held          = 1'b0;
        rate_reg      = cswrle_pkg::C_RATE_RESET;
        total_reg     = '0;
        restart_block();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            case (PLAN[i].kind)
                ROW_RATE: begin
                    settle();
                    write_reg(cswrle_pkg::C_REG_RATE, PLAN[i].value);
                end
                ROW_TOTAL: begin
                    settle();
                    write_reg(cswrle_pkg::C_REG_PULSE_TOTAL, PLAN[i].value);
                end
                default: send_word(mk_word(PLAN[i].value[7:0], PLAN[i].has, PLAN[i].last),
                                   PLAN[i].typed, PLAN[i].res);
            endcase
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin new_rate = 25'd44100;  new_total = 25'($urandom_range(1, 8));  end
                1: begin new_rate = 25'd1;      new_total = 25'($urandom_range(0, 12)); end
                2: begin new_rate = 25'hFFFFFF; new_total = 25'($urandom_range(1, 6));  end
                3: begin new_rate = 25'd0;      new_total = 25'($urandom_range(0, 4));  end
                4: begin new_rate = 25'd48000;  new_total = cswrle_pkg::C_MAX_PULSES;   end
                5: begin
                    new_rate  = 25'($urandom_range(1, 24'hFFFFFF));
                    new_total = 25'h1FFFFFF;
                end
                6: begin new_rate = 25'd22050;  new_total = 25'($urandom_range(0, 16)); end
                default: begin
                    new_rate  = 25'($urandom_range(1, 200000));
                    new_total = 25'($urandom_range(1, 10));
                end
            endcase
            settle();
            write_reg(cswrle_pkg::C_REG_RATE, new_rate);
            write_reg(cswrle_pkg::C_REG_PULSE_TOTAL, new_total);
            traffic_mode = p % 4;
            phase_start  = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                random_block();
                // hold the sender until the output side has caught up
                if (p == 1 && !held && words_sent - phase_start >= PHASE_WORDS / 2) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_pulses.size() != 0)
                        @(posedge i_clk);
                    held = 1'b1;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (bad_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== csw_rle_pulse_decoder_unit.f =====
hdl/cswrle_pkg.sv
hdl/cswrle_mul.sv
hdl/cswrle_div.sv
hdl/csw_rle_pulse_decoder_unit.sv
tb/tb_top.sv
